// ===== design/gntr_pkg.sv =====
// Shared types, constants and the gradient sine table of the terrain height core.
package gntr_pkg;

  localparam int unsigned COORD_BITS    = 24;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned SCALE_FRAC    = 24;
  localparam int unsigned ANGLE_BITS    = 8;
  localparam int unsigned ANGLE_COUNT   = 1 << ANGLE_BITS;
  localparam int unsigned MAX_HEIGHT    = 256;
  localparam int unsigned MAX_OCTAVES   = 8;
  localparam int unsigned MUL_W         = 33;
  localparam int unsigned PROD_W        = 2 * MUL_W;

  localparam logic [31:0] HASH_MUL_X   = 32'h9E3779B1;
  localparam logic [31:0] HASH_MUL_Z   = 32'h85EBCA77;
  localparam logic [31:0] HASH_MUL_MIX = 32'h27D4EB2D;

  localparam logic [2:0] CFG_HASH_SEED   = 3'd0;
  localparam logic [2:0] CFG_INV_SCALE   = 3'd1;
  localparam logic [2:0] CFG_AMPLITUDE   = 3'd2;
  localparam logic [2:0] CFG_OCTAVES     = 3'd3;
  localparam logic [2:0] CFG_BASELINE    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OCTAVE,
    ST_MUL,
    ST_WB,
    ST_DONE
  } state_e;

  typedef enum logic [3:0] {
    OP_SX,
    OP_SZ,
    OP_WX_SQ,
    OP_WX,
    OP_WZ_SQ,
    OP_WZ,
    OP_H1,
    OP_H2,
    OP_H3,
    OP_DX,
    OP_DZ,
    OP_LB,
    OP_LT,
    OP_LV,
    OP_AMP
  } op_e;

  typedef struct packed {
    logic                     en;
    logic signed [MUL_W-1:0]  a;
    logic signed [MUL_W-1:0]  b;
  } mul_req_t;

  typedef logic signed [15:0] sin_lut_t [ANGLE_COUNT];

  function automatic longint quarter_sine(longint x);
    longint x2;
    longint t;
    x2 = (x * x) >>> 14;
    t  = (1160 * x2) >>> 14;
    t  = ((10512 - t) * x2) >>> 14;
    t  = 25736 - t;
    return (t * x) >>> 14;
  endfunction

  function automatic sin_lut_t build_sin_lut();
    sin_lut_t lut;
    longint   ph;
    longint   q;
    longint   r;
    longint   m;
    for (int i = 0; i < ANGLE_COUNT; i++) begin
      ph = longint'(i) << (16 - ANGLE_BITS);
      q  = (ph >> 14) & 3;
      r  = ph & 16'h3FFF;
      m  = ((q & 1) != 0) ? quarter_sine(16384 - r) : quarter_sine(r);
      if ((q & 2) != 0) begin
        m = -m;
      end
      lut[i] = 16'(m);
    end
    return lut;
  endfunction

  localparam sin_lut_t SIN_LUT = build_sin_lut();

endpackage

// ===== design/gntr_mul.sv =====
// Shared signed multiplier with a registered product.
module gntr_mul
  import gntr_pkg::*;
(
  input  logic                     clk_i,
  input  mul_req_t                 req_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= req_i.a * req_i.b;
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== design/gradient_noise_terrain_height_core.sv =====
// Terrain height core: fractal 2-D gradient noise summed over octaves on one multiplier.
//
// One column (column_x, column_z) goes in, one height comes out. Every product of
// the computation runs through a single 33x33 signed multiplier with a registered
// output, under a small sequencer: each octave takes 30 multiplies (position scaling
// on both axes, two smoothstep weights, three hash multiplies and two gradient dot
// terms for each of the four lattice corners, three interpolations and the amplitude
// product), and each multiply has an issue state and a write-back state. The octave
// count is min(octave_count, 8), six at reset. The input is stalled while a column
// is in progress. The result sits in an output register, so the next column is taken
// while a finished height still waits downstream. Configuration writes are always
// accepted and must only be issued while the core is idle.
module gradient_noise_terrain_height_core
  import gntr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Column input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [COORD_BITS-1:0] column_x_i,
  input  logic signed [COORD_BITS-1:0] column_z_i,
  // Height output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [8:0]                   column_height_o,
  output logic                         height_clipped_o,
  // Configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [31:0]                  cfg_data_i
);

  // Configuration registers
  logic [31:0] seed_q;
  logic [23:0] inv_scale_q;
  logic [7:0]  amplitude_q;
  logic [3:0]  octaves_q;
  logic [8:0]  baseline_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      inv_scale_q <= 24'd1048576;
      amplitude_q <= 8'd32;
      octaves_q   <= 4'd6;
      baseline_q  <= 9'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_HASH_SEED: seed_q      <= cfg_data_i;
        CFG_INV_SCALE: inv_scale_q <= cfg_data_i[23:0];
        CFG_AMPLITUDE: amplitude_q <= cfg_data_i[7:0];
        CFG_OCTAVES:   octaves_q   <= cfg_data_i[3:0];
        CFG_BASELINE:  baseline_q  <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // Octave count, capped: further octaves have zero amplitude
  logic [3:0] oct_n;
  assign oct_n = (octaves_q > 4'(MAX_OCTAVES)) ? 4'(MAX_OCTAVES) : octaves_q;

  // Sequencer state
  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic [3:0] k_q, k_d;
  logic [1:0] corner_q, corner_d;

  // Working registers
  logic signed [COORD_BITS-1:0] cx_q, cz_q;
  logic signed [47:0] sx_q, sz_q;
  logic [16:0]        t2_q;
  logic [16:0]        wx_q, wz_q;
  logic [31:0]        hash_q;
  logic signed [33:0] acc_q;
  logic signed [19:0] dot_q [4];
  logic signed [19:0] lb_q, lt_q, v_q;
  logic signed [15:0] sum_q;

  logic               out_valid_q;
  logic [8:0]         height_q;
  logic               clipped_q;

  // Shared multiplier
  mul_req_t                 mul_req;
  logic signed [PROD_W-1:0] prod;

  gntr_mul u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  // Lattice position of the current octave
  logic [15:0]        fx, fz;
  logic [31:0]        x0, z0, cxc, czc;
  logic signed [17:0] dx, dz;
  logic [ANGLE_BITS-1:0] ang;
  logic signed [15:0] gx, gz;

  assign fx  = sx_q[15:0];
  assign fz  = sz_q[15:0];
  assign x0  = sx_q[47:16];
  assign z0  = sz_q[47:16];
  assign cxc = x0 + {31'd0, corner_q[0]};
  assign czc = z0 + {31'd0, corner_q[1]};
  assign dx  = $signed({2'b00, fx}) - (corner_q[0] ? 18'sd65536 : 18'sd0);
  assign dz  = $signed({2'b00, fz}) - (corner_q[1] ? 18'sd65536 : 18'sd0);
  assign ang = hash_q[31:32-ANGLE_BITS];
  assign gz  = SIN_LUT[ang];
  assign gx  = SIN_LUT[ang + ANGLE_BITS'(ANGLE_COUNT / 4)];

  logic [7:0] amp;
  assign amp = amplitude_q >> k_q[2:0];

  // Operand selection for the current operation
  always_comb begin
    mul_req.en = (state_q == ST_MUL);
    mul_req.a  = '0;
    mul_req.b  = '0;
    case (op_q)
      OP_SX: begin
        mul_req.a = MUL_W'(cx_q);
        mul_req.b = $signed({9'd0, inv_scale_q});
      end
      OP_SZ: begin
        mul_req.a = MUL_W'(cz_q);
        mul_req.b = $signed({9'd0, inv_scale_q});
      end
      OP_WX_SQ: begin
        mul_req.a = $signed({17'd0, fx});
        mul_req.b = $signed({17'd0, fx});
      end
      OP_WX: begin
        mul_req.a = $signed({16'd0, t2_q});
        mul_req.b = $signed({15'd0, 18'd196608 - {1'b0, fx, 1'b0}});
      end
      OP_WZ_SQ: begin
        mul_req.a = $signed({17'd0, fz});
        mul_req.b = $signed({17'd0, fz});
      end
      OP_WZ: begin
        mul_req.a = $signed({16'd0, t2_q});
        mul_req.b = $signed({15'd0, 18'd196608 - {1'b0, fz, 1'b0}});
      end
      OP_H1: begin
        mul_req.a = $signed({1'b0, cxc});
        mul_req.b = $signed({1'b0, HASH_MUL_X});
      end
      OP_H2: begin
        mul_req.a = $signed({1'b0, czc});
        mul_req.b = $signed({1'b0, HASH_MUL_Z});
      end
      OP_H3: begin
        mul_req.a = $signed({1'b0, hash_q});
        mul_req.b = $signed({1'b0, HASH_MUL_MIX});
      end
      OP_DX: begin
        mul_req.a = MUL_W'(dx);
        mul_req.b = MUL_W'(gx);
      end
      OP_DZ: begin
        mul_req.a = MUL_W'(dz);
        mul_req.b = MUL_W'(gz);
      end
      OP_LB: begin
        mul_req.a = MUL_W'(21'(dot_q[1]) - 21'(dot_q[0]));
        mul_req.b = $signed({16'd0, wx_q});
      end
      OP_LT: begin
        mul_req.a = MUL_W'(21'(dot_q[3]) - 21'(dot_q[2]));
        mul_req.b = $signed({16'd0, wx_q});
      end
      OP_LV: begin
        mul_req.a = MUL_W'(21'(lt_q) - 21'(lb_q));
        mul_req.b = $signed({16'd0, wz_q});
      end
      OP_AMP: begin
        mul_req.a = MUL_W'(v_q);
        mul_req.b = $signed({25'd0, amp});
      end
      default: ;
    endcase
  end

  // Write-back helpers
  logic signed [PROD_W-1:0] sh_pos;
  logic signed [PROD_W-1:0] sh_lerp;
  logic [31:0]              mix_h2;
  logic [31:0]              lo;
  logic signed [33:0]       dot_sum;
  logic signed [21:0]       lerp_a;
  logic signed [21:0]       lerp_r;
  logic signed [30:0]       p_amp;
  logic signed [30:0]       p_neg;
  logic signed [15:0]       contrib;
  logic signed [17:0]       raw;

  assign sh_pos  = prod <<< k_q[2:0];
  assign sh_lerp = prod >>> FRACTION_BITS;
  assign lo      = prod[31:0];
  assign mix_h2  = hash_q ^ lo;
  assign dot_sum = acc_q + prod[33:0];
  assign lerp_a  = (op_q == OP_LB) ? 22'(dot_q[0]) :
                   (op_q == OP_LT) ? 22'(dot_q[2]) : 22'(lb_q);
  assign lerp_r  = lerp_a + sh_lerp[21:0];
  assign p_amp   = prod[30:0];
  assign p_neg   = -p_amp;
  assign contrib = p_amp[30] ? -16'(p_neg >>> FRACTION_BITS)
                             : 16'(p_amp >>> FRACTION_BITS);
  assign raw     = $signed({9'd0, baseline_q}) + 18'(sum_q);

  // Next state
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    k_d      = k_q;
    corner_d = corner_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_OCTAVE;
          k_d     = '0;
        end
      end
      ST_OCTAVE: begin
        // enter an octave or finish
        op_d     = OP_SX;
        corner_d = '0;
        state_d  = (k_q == oct_n) ? ST_DONE : ST_MUL;
      end
      ST_MUL: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        state_d = ST_MUL;
        case (op_q)
          OP_SX:    op_d = OP_SZ;
          OP_SZ:    op_d = OP_WX_SQ;
          OP_WX_SQ: op_d = OP_WX;
          OP_WX:    op_d = OP_WZ_SQ;
          OP_WZ_SQ: op_d = OP_WZ;
          OP_WZ:    op_d = OP_H1;
          OP_H1:    op_d = OP_H2;
          OP_H2:    op_d = OP_H3;
          OP_H3:    op_d = OP_DX;
          OP_DX:    op_d = OP_DZ;
          OP_DZ: begin
            if (corner_q == 2'd3) begin
              op_d = OP_LB;
            end else begin
              op_d     = OP_H1;
              corner_d = corner_q + 2'd1;
            end
          end
          OP_LB:    op_d = OP_LT;
          OP_LT:    op_d = OP_LV;
          OP_LV:    op_d = OP_AMP;
          OP_AMP: begin
            k_d     = k_q + 4'd1;
            state_d = ST_OCTAVE;
          end
          default:  op_d = OP_SX;
        endcase
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_SX;
      k_q      <= '0;
      corner_q <= '0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      k_q      <= k_d;
      corner_q <= corner_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      cx_q  <= column_x_i;
      cz_q  <= column_z_i;
      sum_q <= '0;
    end
    if (state_q == ST_WB) begin
      case (op_q)
        OP_SX:    sx_q   <= sh_pos[55:8];
        OP_SZ:    sz_q   <= sh_pos[55:8];
        OP_WX_SQ: t2_q   <= {1'b0, prod[31:16]};
        OP_WX:    wx_q   <= prod[32:16];
        OP_WZ_SQ: t2_q   <= {1'b0, prod[31:16]};
        OP_WZ:    wz_q   <= prod[32:16];
        OP_H1:    hash_q <= seed_q ^ lo;
        OP_H2:    hash_q <= mix_h2 ^ (mix_h2 >> 16);
        OP_H3:    hash_q <= lo ^ (lo >> 15);
        OP_DX:    acc_q  <= prod[33:0];
        OP_DZ:    dot_q[corner_q] <= dot_sum[33:14];
        OP_LB:    lb_q   <= lerp_r[19:0];
        OP_LT:    lt_q   <= lerp_r[19:0];
        OP_LV:    v_q    <= lerp_r[19:0];
        OP_AMP:   sum_q  <= sum_q + contrib;
        default: ;
      endcase
    end
  end

  // Output register: saturate the raw height
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && (!out_valid_q || !out_stall_i)) begin
      if (raw < 0) begin
        height_q  <= '0;
        clipped_q <= 1'b1;
      end else if (raw > $signed(18'(MAX_HEIGHT))) begin
        height_q  <= 9'(MAX_HEIGHT);
        clipped_q <= 1'b1;
      end else begin
        height_q  <= raw[8:0];
        clipped_q <= 1'b0;
      end
    end
  end

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign column_height_o  = height_q;
  assign height_clipped_o = clipped_q;

  // Checks
  a_octave_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    k_q <= 4'(MAX_OCTAVES))
    else $error("octave counter ran past the cap");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> column_height_o <= 9'(MAX_HEIGHT))
    else $error("height above maximum");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && !out_stall_i) |=> (state_q == ST_IDLE && out_valid_o))
    else $error("finished result not delivered to output register");

  a_mul_then_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MUL |=> state_q == ST_WB)
    else $error("multiply not followed by write back");

endmodule
